// ===== rtl/asq_pkg.sv =====
// Shared codes and widths for the adaptable sorted priority queue.
// Depends on nothing; used by the slot RAM and the top level.
package asq_pkg;

    // Handles are 4-bit tags; at most sixteen entries can be live at once.
    localparam int TAG_W     = 4;
    localparam int TAG_COUNT = 16;
    localparam int COUNT_W   = 5;
    localparam int OUT_KEY_W = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_REMOVE_MIN = 2'd1,
        FUNC_REMOVE     = 2'd2,
        FUNC_REPLACE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_BAD_HANDLE = 2'd3
    } status_t;

endpackage

// ===== rtl/adaptable_sorted_priority_queue.sv =====
// Top level of the adaptable sorted priority queue: sequencer, tag map, outputs.
// Depends on asq_pkg and asq_slot_ram.
//
// Channel   Direction  Handshake          Fields
// command   in         start, busy        func, key, handle
// result    out        done (one cycle)   status, new_handle, min_key, count, is_empty
//
// One command at a time. Every slot visited is read, then compared and written
// back; a rejected command goes straight to the minimum read and the report.
// Reset clears the tag map and the count; the slot RAM needs no clearing. done
// is high for one cycle and cannot stall; busy is low in that cycle, so a new
// command can follow.
module adaptable_sorted_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [31:0]                  key,
    input  logic [asq_pkg::TAG_W-1:0]           handle,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [asq_pkg::TAG_W-1:0]           new_handle,
    output logic signed [31:0]                  min_key,
    output logic [asq_pkg::COUNT_W-1:0]         count,
    output logic                                is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_GO,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_MIN_RD,
        S_REPORT
    } state_t;

    state_t                              state_reg;
    asq_pkg::func_t                      func_reg;
    logic signed [KEY_WIDTH-1:0]         key_reg;
    logic [asq_pkg::TAG_W-1:0]           handle_reg;
    logic [asq_pkg::TAG_W-1:0]           tag_reg;
    logic [CW-1:0]                       idx_reg;
    logic                                found_reg;
    logic [asq_pkg::COUNT_W-1:0]         count_reg;
    logic [asq_pkg::TAG_COUNT-1:0]       tag_in_use_reg;
    logic [1:0]                          status_reg;
    logic [asq_pkg::TAG_W-1:0]           new_handle_reg;
    logic signed [31:0]                  min_key_reg;
    logic                                done_reg;

    logic                                ram_wr_en;
    logic [AW-1:0]                       ram_wr_addr;
    logic [KEY_WIDTH-1:0]                ram_wr_key;
    logic [asq_pkg::TAG_W-1:0]           ram_wr_tag;
    logic                                ram_rd_en;
    logic [AW-1:0]                       ram_rd_addr;
    logic signed [KEY_WIDTH-1:0]         rd_key;
    logic [asq_pkg::TAG_W-1:0]           rd_tag;

    logic [asq_pkg::TAG_W-1:0]           free_tag;
    logic                                queue_full;
    logic [CW-1:0]                       idx_dec;
    logic [CW-1:0]                       idx_inc;
    logic                                hit;
    logic                                shift_up;
    logic signed [63:0]                  key_in_wide;
    logic signed [63:0]                  rd_key_wide;

    asq_slot_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_key  (ram_wr_key),
        .wr_tag  (ram_wr_tag),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_key  (rd_key),
        .rd_tag  (rd_tag)
    );

    // Lowest free handle and the full condition.
    always_comb
    begin
        free_tag = '0;
        for (int t = asq_pkg::TAG_COUNT - 1; t >= 0; t--)
        begin
            if (!tag_in_use_reg[t])
            begin
                free_tag = asq_pkg::TAG_W'(t);
            end
        end
    end

    assign queue_full = (&tag_in_use_reg) || (32'(count_reg) >= 32'(DEPTH));

    // Scan helpers.
    assign idx_dec     = idx_reg - CW'(1);
    assign idx_inc     = idx_reg + CW'(1);
    assign hit         = !found_reg &&
                         ((func_reg == asq_pkg::FUNC_REMOVE_MIN) ? (idx_reg == '0)
                                                                  : (rd_tag == handle_reg));
    assign shift_up    = (rd_key >= key_reg);
    assign key_in_wide = 64'(key);
    assign rd_key_wide = 64'(rd_key);

    // Slot RAM access for each sequencer step.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[AW-1:0];
        ram_wr_key  = key_reg;
        ram_wr_tag  = tag_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg[AW-1:0];
        case (state_reg)
            S_FIND_RD:
            begin
                ram_rd_en = 1'b1;
            end
            S_FIND_CMP:
            begin
                // Entries behind the removed one move down by one slot.
                ram_wr_en   = found_reg;
                ram_wr_addr = idx_dec[AW-1:0];
                ram_wr_key  = rd_key;
                ram_wr_tag  = rd_tag;
            end
            S_INS_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_dec[AW-1:0];
            end
            S_INS_CMP:
            begin
                // Larger or equal entries move up; otherwise the new entry lands here.
                ram_wr_en = 1'b1;
                if (shift_up)
                begin
                    ram_wr_key = rd_key;
                    ram_wr_tag = rd_tag;
                end
            end
            S_INS_PUT:
            begin
                ram_wr_en = 1'b1;
            end
            S_MIN_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            tag_in_use_reg <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            status_reg     <= asq_pkg::STAT_OK;
            new_handle_reg <= '0;
            min_key_reg    <= '0;
            func_reg       <= asq_pkg::FUNC_INSERT;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        func_reg       <= asq_pkg::func_t'(func);
                        key_reg        <= key_in_wide[KEY_WIDTH-1:0];
                        handle_reg     <= handle;
                        new_handle_reg <= '0;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        case (asq_pkg::func_t'(func))
                            asq_pkg::FUNC_INSERT:
                            begin
                                if (queue_full)
                                begin
                                    status_reg <= asq_pkg::STAT_FULL;
                                    state_reg  <= S_MIN_RD;
                                end
                                else
                                begin
                                    status_reg <= asq_pkg::STAT_OK;
                                    state_reg  <= S_INS_GO;
                                end
                            end
                            asq_pkg::FUNC_REMOVE_MIN:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= asq_pkg::STAT_EMPTY;
                                    state_reg  <= S_MIN_RD;
                                end
                                else
                                begin
                                    status_reg <= asq_pkg::STAT_OK;
                                    state_reg  <= S_FIND_RD;
                                end
                            end
                            default:
                            begin
                                if (!tag_in_use_reg[handle])
                                begin
                                    status_reg <= asq_pkg::STAT_BAD_HANDLE;
                                    state_reg  <= S_MIN_RD;
                                end
                                else
                                begin
                                    status_reg <= asq_pkg::STAT_OK;
                                    state_reg  <= S_FIND_RD;
                                end
                            end
                        endcase
                    end
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_CMP;
                end
                S_FIND_CMP:
                begin
                    if (hit)
                    begin
                        found_reg              <= 1'b1;
                        tag_in_use_reg[rd_tag] <= 1'b0;
                    end
                    idx_reg <= idx_inc;
                    if (32'(idx_inc) == 32'(count_reg))
                    begin
                        count_reg <= count_reg - asq_pkg::COUNT_W'(1);
                        if (func_reg == asq_pkg::FUNC_REPLACE)
                        begin
                            state_reg <= S_INS_GO;
                        end
                        else
                        begin
                            state_reg <= S_MIN_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FIND_RD;
                    end
                end
                S_INS_GO:
                begin
                    tag_reg <= free_tag;
                    idx_reg <= CW'(count_reg);
                    if (count_reg == '0)
                    begin
                        state_reg <= S_INS_PUT;
                    end
                    else
                    begin
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_CMP;
                end
                S_INS_CMP:
                begin
                    if (shift_up)
                    begin
                        idx_reg <= idx_dec;
                        if (idx_dec == '0)
                        begin
                            state_reg <= S_INS_PUT;
                        end
                        else
                        begin
                            state_reg <= S_INS_RD;
                        end
                    end
                    else
                    begin
                        count_reg               <= count_reg + asq_pkg::COUNT_W'(1);
                        tag_in_use_reg[tag_reg] <= 1'b1;
                        new_handle_reg          <= tag_reg;
                        state_reg               <= S_MIN_RD;
                    end
                end
                S_INS_PUT:
                begin
                    count_reg               <= count_reg + asq_pkg::COUNT_W'(1);
                    tag_in_use_reg[tag_reg] <= 1'b1;
                    new_handle_reg          <= tag_reg;
                    state_reg               <= S_MIN_RD;
                end
                S_MIN_RD:
                begin
                    state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    min_key_reg <= (count_reg == '0) ? '0 : rd_key_wide[31:0];
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result transfer and handshake outputs.
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign new_handle = new_handle_reg;
    assign min_key    = min_key_reg;
    assign count      = count_reg;
    assign is_empty   = (count_reg == '0);

endmodule

// ===== rtl/asq_slot_ram.sv =====
// Single-port-write, single-port-read slot RAM holding key and tag per slot.
// Depends on asq_pkg for the tag width.
module asq_slot_ram #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [KEY_WIDTH-1:0]         wr_key,
    input  logic [asq_pkg::TAG_W-1:0]    wr_tag,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [KEY_WIDTH-1:0]         rd_key,
    output logic [asq_pkg::TAG_W-1:0]    rd_tag
);

    logic [KEY_WIDTH-1:0]      key_mem [DEPTH];
    logic [asq_pkg::TAG_W-1:0] tag_mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            tag_mem[wr_addr] <= wr_tag;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key <= key_mem[rd_addr];
            rd_tag <= tag_mem[rd_addr];
        end
    end

endmodule
